### src/wtrm_pkg.sv
// ----------------------------------------------------------------------------
// wtrm_pkg
// Shared widths, codes and types of the windowed transfer rate meter.
// ----------------------------------------------------------------------------
package wtrm_pkg;

    localparam int TIME_W     = 48;
    localparam int BYTES_W    = 48;
    localparam int COUNT_W    = 32;
    localparam int RATE_W     = 56;
    localparam int CFG_W      = 16;
    localparam int DIVIDEND_W = 56;
    localparam int DIV_CNT_W  = 6;

    localparam logic [7:0]       RATE_SCALE   = 8'd250;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 16'd2000;
    localparam logic [CFG_W-1:0] GRAN_RESET   = 16'd250;

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic {
        REG_WINDOW = 1'b0,
        REG_GRAN   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REC,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]  time_ms;
        logic [BYTES_W-1:0] bytes;
    } bin_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### src/wtrm_bin_store.sv
// ----------------------------------------------------------------------------
// wtrm_bin_store
// History bin memory: one write port, one registered read port, and a valid
// bit per entry so that an unwritten bin reads as zero.
// ----------------------------------------------------------------------------
module wtrm_bin_store #(
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output wtrm_pkg::bin_t  rd_data,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  wtrm_pkg::bin_t  wr_data
);
    import wtrm_pkg::*;

    bin_t             bin_mem_reg [DEPTH];
    bin_t             rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bin_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= bin_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### src/wtrm_divider.sv
// ----------------------------------------------------------------------------
// wtrm_divider
// Restoring divider, one quotient bit per cycle, for the scaled byte sum
// over the window length.
// ----------------------------------------------------------------------------
module wtrm_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [wtrm_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [wtrm_pkg::CFG_W-1:0]          divisor,
    output logic [wtrm_pkg::DIVIDEND_W-1:0]     quotient,
    output wtrm_pkg::div_status_t               status
);
    import wtrm_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [CFG_W-1:0]      rem_reg;
    logic [CFG_W-1:0]      divisor_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [CFG_W:0]        shifted;
    logic [CFG_W:0]        diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### src/windowed_transfer_rate_meter.sv
// ----------------------------------------------------------------------------
// windowed_transfer_rate_meter
// Ring of time-stamped byte bins in a small memory, with a sequencer that
// records transfers and answers windowed rate queries.
// ----------------------------------------------------------------------------
// Record word: bin read, then read-modify-write of the newest bin, or a new bin after it.
// Query word: from acceptance, the walk over B bins, the multiply state, the
//   56-step serial divider and its done strobe, then the result register once
//   any waiting result is taken; B the bins walked (0 when now is below the window, else 1..HISTORY_BINS).
// One word at a time; a record may be taken while a result waits.
// Synchronous active-low reset: bins read as zero, newest index 0,
//   window 2000 ms, granularity 250 ms; no clearing pass.
module windowed_transfer_rate_meter #(
    parameter int HISTORY_BINS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [0:0]                           cfg_index,
    input  logic [wtrm_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [wtrm_pkg::TIME_W-1:0]          s_now_msec,
    input  logic [wtrm_pkg::COUNT_W-1:0]         s_byte_count,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [wtrm_pkg::BYTES_W-1:0]         m_window_bytes,
    output logic [wtrm_pkg::RATE_W-1:0]          m_rate_q8
);
    import wtrm_pkg::*;

    localparam int            AW   = $clog2(HISTORY_BINS);
    localparam logic [AW-1:0] LAST = AW'(HISTORY_BINS - 1);
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     win_reg;
    logic [CFG_W-1:0]     gran_reg;
    logic [AW-1:0]        newest_reg;
    logic [AW-1:0]        idx_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [TIME_W-1:0]    cutoff_reg;
    logic [BYTES_W-1:0]   sum_reg;
    logic                 m_valid_reg;
    logic [BYTES_W-1:0]   m_window_bytes_reg;
    logic [RATE_W-1:0]    m_rate_q8_reg;

    logic                 accept;
    logic                 early;
    bin_t                 rd_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    bin_t                 wr_data;
    logic [AW-1:0]        newest_inc;
    logic [AW-1:0]        idx_prev;
    logic                 rec_hit;
    logic [BYTES_W:0]     rec_sum;
    logic [BYTES_W-1:0]   rec_bytes;
    logic [BYTES_W:0]     walk_sum;
    logic [BYTES_W-1:0]   walk_bytes;
    logic                 walk_older;
    logic                 walk_stop;
    logic                 div_start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [CFG_W-1:0]     divisor;
    logic [DIVIDEND_W-1:0] quotient;
    div_status_t          div_status;
    logic                 out_load;

    wtrm_bin_store #(
        .DEPTH (HISTORY_BINS)
    ) u_bins (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    wtrm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .status   (div_status)
    );

    assign accept     = s_valid && s_ready;
    assign early      = s_now_msec < {{(TIME_W-CFG_W){1'b0}}, win_reg};
    assign newest_inc = (newest_reg == LAST) ? '0 : newest_reg + 1'b1;
    assign idx_prev   = (idx_reg == '0) ? LAST : idx_reg - 1'b1;

    // bin still open while its time plus granularity reaches now
    assign rec_hit   = ({1'b0, rd_data.time_ms} + {{(TIME_W-CFG_W+1){1'b0}}, gran_reg})
                       >= {1'b0, now_reg};
    assign rec_sum   = {1'b0, rd_data.bytes} + {{(BYTES_W-COUNT_W+1){1'b0}}, count_reg};
    assign rec_bytes = rec_sum[BYTES_W] ? BYTES_MAX : rec_sum[BYTES_W-1:0];

    assign walk_older = rd_data.time_ms <= cutoff_reg;
    assign walk_sum   = {1'b0, sum_reg} + {1'b0, rd_data.bytes};
    assign walk_bytes = walk_sum[BYTES_W] ? BYTES_MAX : walk_sum[BYTES_W-1:0];
    assign walk_stop  = walk_older || (idx_prev == newest_reg);

    assign dividend = DIVIDEND_W'(sum_reg) * DIVIDEND_W'(RATE_SCALE);
    assign divisor  = (win_reg == '0) ? CFG_W'(1) : win_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_RECORD) begin
                        state_next = ST_REC;
                    end else if (early) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_REC:  state_next = ST_IDLE;
            ST_WALK: begin
                if (walk_stop) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = newest_reg;
        wr_en     = 1'b0;
        wr_addr   = newest_reg;
        wr_data   = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                rd_en   = s_valid;
            end
            ST_REC: begin
                wr_en = 1'b1;
                if (rec_hit) begin
                    wr_data = '{time_ms: rd_data.time_ms, bytes: rec_bytes};
                end else begin
                    wr_addr = newest_inc;
                    wr_data = '{time_ms: now_reg, bytes: BYTES_W'(count_reg)};
                end
            end
            ST_WALK: begin
                rd_en   = !walk_stop;
                rd_addr = idx_prev;
            end
            ST_MUL:  div_start = 1'b1;
            ST_DIV:  ;
            ST_DONE: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_reg     <= WINDOW_RESET;
            gran_reg    <= GRAN_RESET;
            newest_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_index))
                    REG_WINDOW: win_reg  <= cfg_wdata;
                    REG_GRAN:   gran_reg <= cfg_wdata;
                    default:    ;
                endcase
            end
            if (state_reg == ST_REC && !rec_hit) begin
                newest_reg <= newest_inc;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg    <= s_now_msec;
            count_reg  <= s_byte_count;
            cutoff_reg <= s_now_msec - {{(TIME_W-CFG_W){1'b0}}, win_reg};
            sum_reg    <= '0;
            idx_reg    <= newest_reg;
        end else if (state_reg == ST_WALK) begin
            if (!walk_older) begin
                sum_reg <= walk_bytes;
            end
            idx_reg <= idx_prev;
        end
        if (out_load) begin
            m_window_bytes_reg <= sum_reg;
            m_rate_q8_reg      <= quotient;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_window_bytes = m_window_bytes_reg;
    assign m_rate_q8      = m_rate_q8_reg;

endmodule

### src/wtrm_checker.sv
// ----------------------------------------------------------------------------
// wtrm_checker
// Port-level checks on the result channel of the rate meter.
// ----------------------------------------------------------------------------
module wtrm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [wtrm_pkg::BYTES_W-1:0]   m_window_bytes,
    input logic [wtrm_pkg::RATE_W-1:0]    m_rate_q8
);
    import wtrm_pkg::*;

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_bytes) && $stable(m_rate_q8))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_rate_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rate_q8 <= RATE_W'(m_window_bytes) * RATE_W'(RATE_SCALE))
        else $error("rate exceeds scaled byte sum");

    a_zero_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_window_bytes == '0) |-> m_rate_q8 == '0)
        else $error("non-zero rate for an empty window");

endmodule

bind windowed_transfer_rate_meter wtrm_checker u_wtrm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_window_bytes (m_window_bytes),
    .m_rate_q8      (m_rate_q8)
);
